// ===== sv/twdb_pkg.sv =====
// Package for the two-wire debug bit engine.
// Holds command codes, register indexes, field widths and the structs that
// pass between the configuration block, the sequencer and the top level.
package twdb_pkg;

	// Field widths fixed by the item format
	localparam int FUNC_W = 3;
	localparam int DATA_W = 32;
	localparam int CNT_W  = 6;
	localparam int DIV_W  = 16;

	// Command codes; codes above FUNC_SHIFT_IN act as plain ticks
	typedef enum logic [FUNC_W-1:0] {
		FUNC_TICK      = 3'd0,
		FUNC_START     = 3'd1,
		FUNC_STOP      = 3'd2,
		FUNC_SHIFT_OUT = 3'd3,
		FUNC_SHIFT_IN  = 3'd4
	} func_t;

	// Register indexes on the APB port (byte address = 4 * index)
	localparam logic [0:0] REG_CLOCK_DIVIDER = 1'b0;
	localparam logic [0:0] REG_FAST_MODE     = 1'b1;

	// Configuration seen by the sequencer
	typedef struct packed {
		logic [DIV_W-1:0] clock_divider;
		logic             fast_mode;
	} cfg_t;

	// One result word
	typedef struct packed {
		logic              clk_level;
		logic              dio_level;
		logic              dio_drive;
		logic              busy_res;
		logic              done_res;
		logic [DATA_W-1:0] read_value;
		logic              rejected;
	} res_t;

endpackage

// ===== sv/twdb_cmd_if.sv =====
// Command channel of the two-wire debug bit engine: valid/ready plus one
// command word. Depends on twdb_pkg for field widths.
interface twdb_cmd_if;
	logic                           valid;
	logic                           ready;
	logic [twdb_pkg::FUNC_W-1:0]    func;
	logic [twdb_pkg::DATA_W-1:0]    out_bits;
	logic [twdb_pkg::CNT_W-1:0]     bit_count;
	logic                           dio_in;

	modport source (output valid, func, out_bits, bit_count, dio_in, input ready);
	modport sink   (input valid, func, out_bits, bit_count, dio_in, output ready);
endinterface

// ===== sv/twdb_res_if.sv =====
// Result channel of the two-wire debug bit engine: valid/ready plus one
// result word. Depends on twdb_pkg for field widths.
interface twdb_res_if;
	logic                           valid;
	logic                           ready;
	logic                           clk_level;
	logic                           dio_level;
	logic                           dio_drive;
	logic                           busy_res;
	logic                           done_res;
	logic [twdb_pkg::DATA_W-1:0]    read_value;
	logic                           rejected;

	modport source (output valid, clk_level, dio_level, dio_drive, busy_res, done_res,
		read_value, rejected, input ready);
	modport sink   (input valid, clk_level, dio_level, dio_drive, busy_res, done_res,
		read_value, rejected, output ready);
endinterface

// ===== sv/twdb_cfg.sv =====
// APB register block of the two-wire debug bit engine: clock divider and
// fast mode. Depends on twdb_pkg for register indexes and the cfg_t struct.
module twdb_cfg (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        psel,
	input  logic                        penable,
	input  logic                        pwrite,
	input  logic [2:0]                  paddr,
	input  logic [31:0]                 pwdata,
	output logic [31:0]                 prdata,
	output logic                        pready,
	output twdb_pkg::cfg_t              cfg
);

	logic [twdb_pkg::DIV_W-1:0] div_q;
	logic                       fast_q;
	logic                       wr_en;

	assign pready = 1'b1;
	assign wr_en  = psel & penable & pwrite;

	// Register writes in the access phase
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			div_q  <= '0;
			fast_q <= 1'b0;
		end else if (wr_en) begin
			case (paddr[2])
				twdb_pkg::REG_CLOCK_DIVIDER: div_q  <= pwdata[twdb_pkg::DIV_W-1:0];
				twdb_pkg::REG_FAST_MODE:     fast_q <= pwdata[0];
				default: ;
			endcase
		end
	end

	// Read-back
	always_comb begin
		case (paddr[2])
			twdb_pkg::REG_CLOCK_DIVIDER: prdata = {{(32-twdb_pkg::DIV_W){1'b0}}, div_q};
			twdb_pkg::REG_FAST_MODE:     prdata = {31'b0, fast_q};
			default:                     prdata = '0;
		endcase
	end

	assign cfg.clock_divider = div_q;
	assign cfg.fast_mode     = fast_q;

endmodule

// ===== sv/twdb_seq.sv =====
// Pin sequencer of the two-wire debug bit engine: phase, hold counter, shift
// registers and line levels, advanced by one word per step. Depends on twdb_pkg.
module twdb_seq #(
	parameter int MAX_BITS = 32
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         step,
	input  logic [twdb_pkg::FUNC_W-1:0]  func,
	input  logic [twdb_pkg::DATA_W-1:0]  out_bits,
	input  logic [twdb_pkg::CNT_W-1:0]   bit_count,
	input  logic                         dio_in,
	input  twdb_pkg::cfg_t               cfg,
	output twdb_pkg::res_t               res
);

	localparam int BL_W = $clog2(MAX_BITS + 1);

	typedef enum logic [3:0] {
		PH_IDLE, PH_START_IDLE, PH_START_LOW, PH_STOP_SETUP, PH_STOP_HIGH,
		PH_STOP_RISE, PH_OUT_LOW, PH_OUT_HIGH, PH_IN_LOW, PH_IN_HIGH
	} phase_t;

	phase_t                      phase_q, phase_n, enter_ph;
	logic [twdb_pkg::DIV_W-1:0]  hold_q, hold_n, reload;
	logic [BL_W-1:0]             bits_q, bits_n, count_sat;
	logic [MAX_BITS-1:0]         send_q, send_n, gather_q, gather_n, send_sh;
	logic                        clk_q, clk_n, dat_q, dat_n, drv_q, drv_n;
	logic                        do_enter, is_cmd, final_lvl;

	assign reload    = cfg.fast_mode ? '0 : cfg.clock_divider;
	assign is_cmd    = (func == twdb_pkg::FUNC_START) || (func == twdb_pkg::FUNC_STOP) ||
		(func == twdb_pkg::FUNC_SHIFT_OUT) || (func == twdb_pkg::FUNC_SHIFT_IN);
	assign count_sat = (32'(bit_count) > MAX_BITS) ? BL_W'(MAX_BITS) : BL_W'(bit_count);

	// Next state and result for one word
	always_comb begin
		phase_n  = phase_q;
		hold_n   = hold_q;
		bits_n   = bits_q;
		send_n   = send_q;
		gather_n = gather_q;
		clk_n    = clk_q;
		dat_n    = dat_q;
		drv_n    = drv_q;
		do_enter = 1'b0;
		enter_ph = PH_IDLE;
		send_sh  = '0;
		final_lvl = 1'b0;
		res      = '0;

		if (phase_q != PH_IDLE) begin
			res.rejected = is_cmd;
			if (hold_q != '0) begin
				hold_n = hold_q - twdb_pkg::DIV_W'(1);
			end else begin
				case (phase_q)
					PH_START_IDLE: begin do_enter = 1'b1; enter_ph = PH_START_LOW; end
					PH_STOP_SETUP: begin do_enter = 1'b1; enter_ph = PH_STOP_HIGH; end
					PH_STOP_HIGH:  begin do_enter = 1'b1; enter_ph = PH_STOP_RISE; end
					PH_OUT_LOW:    begin do_enter = 1'b1; enter_ph = PH_OUT_HIGH;  end
					PH_OUT_HIGH:   begin do_enter = 1'b1; enter_ph = PH_OUT_LOW;   end
					PH_IN_LOW:     begin do_enter = 1'b1; enter_ph = PH_IN_HIGH;   end
					PH_IN_HIGH:    begin do_enter = 1'b1; enter_ph = PH_IN_LOW;    end
					default:       phase_n = PH_IDLE;
				endcase
			end
		end else begin
			case (func)
				twdb_pkg::FUNC_START: begin do_enter = 1'b1; enter_ph = PH_START_IDLE; end
				twdb_pkg::FUNC_STOP:  begin do_enter = 1'b1; enter_ph = PH_STOP_SETUP; end
				twdb_pkg::FUNC_SHIFT_OUT: begin
					drv_n  = 1'b1;
					send_n = MAX_BITS'(out_bits);
					bits_n = count_sat;
					if (count_sat == '0) res.done_res = 1'b1;
					else begin do_enter = 1'b1; enter_ph = PH_OUT_LOW; end
				end
				twdb_pkg::FUNC_SHIFT_IN: begin
					drv_n    = 1'b0;
					gather_n = '0;
					bits_n   = count_sat;
					if (count_sat == '0) res.done_res = 1'b1;
					else begin do_enter = 1'b1; enter_ph = PH_IN_LOW; end
				end
				default: ;
			endcase
		end

		// Entering a level: reload the hold (cleared for the stop rise) and set the lines
		if (do_enter) begin
			phase_n = enter_ph;
			hold_n  = reload;
			case (enter_ph)
				PH_START_IDLE: begin drv_n = 1'b1; dat_n = 1'b1; clk_n = 1'b1; end
				PH_START_LOW:  dat_n = 1'b0;
				PH_STOP_SETUP: begin clk_n = 1'b0; drv_n = 1'b1; dat_n = 1'b0; end
				PH_STOP_HIGH:  clk_n = 1'b1;
				PH_STOP_RISE:  begin dat_n = 1'b1; hold_n = '0; end
				PH_OUT_LOW: begin
					clk_n   = 1'b0;
					send_sh = send_n >> (bits_n - BL_W'(1));
					if (bits_n != '0) dat_n = send_sh[0];
				end
				PH_OUT_HIGH: begin
					clk_n = 1'b1;
					if (bits_n != '0) bits_n = bits_n - BL_W'(1);
				end
				PH_IN_LOW: clk_n = 1'b0;
				PH_IN_HIGH: begin
					clk_n    = 1'b1;
					gather_n = (gather_n << 1) | MAX_BITS'(dio_in);
					if (bits_n != '0) bits_n = bits_n - BL_W'(1);
				end
				default: ;
			endcase
		end

		// Last level of a command finishing on this tick
		if (phase_q != PH_IDLE) begin
			final_lvl = (phase_n == PH_START_LOW) || (phase_n == PH_STOP_RISE) ||
				(((phase_n == PH_OUT_HIGH) || (phase_n == PH_IN_HIGH)) && (bits_n == '0));
			if (final_lvl && (hold_n == '0)) begin
				res.done_res = 1'b1;
				if (phase_n == PH_IN_HIGH) res.read_value = twdb_pkg::DATA_W'(gather_n);
				phase_n = PH_IDLE;
			end
		end

		res.clk_level = clk_n;
		res.dio_level = dat_n;
		res.dio_drive = drv_n;
		res.busy_res  = (phase_n != PH_IDLE);
	end

	// State registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q  <= PH_IDLE;
			hold_q   <= '0;
			bits_q   <= '0;
			send_q   <= '0;
			gather_q <= '0;
			clk_q    <= 1'b1;
			dat_q    <= 1'b1;
			drv_q    <= 1'b0;
		end else if (step) begin
			phase_q  <= phase_n;
			hold_q   <= hold_n;
			bits_q   <= bits_n;
			send_q   <= send_n;
			gather_q <= gather_n;
			clk_q    <= clk_n;
			dat_q    <= dat_n;
			drv_q    <= drv_n;
		end
	end

endmodule

// ===== sv/two_wire_debug_bit_engine.sv =====
// Two-wire debug bit engine: clock and data line sequencer, one tick per word.
// Words pass the input and result registers; a result not taken holds both.
// One word per cycle otherwise; the sequencer state advances in a single pass.
// Reset (arst_n low): clock and data lines idle high, data floating, idle phase,
// registers cleared; pipeline and result register empty.
module two_wire_debug_bit_engine #(
	parameter int MAX_BITS = 32
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          psel,
	input  logic          penable,
	input  logic          pwrite,
	input  logic [2:0]    paddr,
	input  logic [31:0]   pwdata,
	output logic [31:0]   prdata,
	output logic          pready,
	twdb_cmd_if.sink      cmd,
	twdb_res_if.source    res
);

	twdb_pkg::cfg_t                cfg;
	twdb_pkg::res_t                step_res, res_q;
	logic                          valid_s1, res_valid_q, advance, step;
	logic [twdb_pkg::FUNC_W-1:0]   func_s1;
	logic [twdb_pkg::DATA_W-1:0]   out_bits_s1;
	logic [twdb_pkg::CNT_W-1:0]    bit_count_s1;
	logic                          dio_s1;

	twdb_cfg u_cfg (
		.clk, .arst_n, .psel, .penable, .pwrite, .paddr, .pwdata,
		.prdata, .pready, .cfg
	);

	// Flow control: the input register moves on whenever the result slot frees
	assign advance   = !res_valid_q || res.ready;
	assign cmd.ready = !valid_s1 || advance;
	assign step      = valid_s1 && advance;

	// Input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) valid_s1 <= 1'b0;
		else if (cmd.ready) valid_s1 <= cmd.valid;
	end

	always_ff @(posedge clk) begin
		if (cmd.valid && cmd.ready) begin
			func_s1      <= cmd.func;
			out_bits_s1  <= cmd.out_bits;
			bit_count_s1 <= cmd.bit_count;
			dio_s1       <= cmd.dio_in;
		end
	end

	twdb_seq #(.MAX_BITS(MAX_BITS)) u_seq (
		.clk, .arst_n, .step,
		.func(func_s1), .out_bits(out_bits_s1), .bit_count(bit_count_s1),
		.dio_in(dio_s1), .cfg, .res(step_res)
	);

	// Result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) res_valid_q <= 1'b0;
		else if (advance) res_valid_q <= valid_s1;
	end

	always_ff @(posedge clk) begin
		if (step) res_q <= step_res;
	end

	assign res.valid      = res_valid_q;
	assign res.clk_level  = res_q.clk_level;
	assign res.dio_level  = res_q.dio_level;
	assign res.dio_drive  = res_q.dio_drive;
	assign res.busy_res   = res_q.busy_res;
	assign res.done_res   = res_q.done_res;
	assign res.read_value = res_q.read_value;
	assign res.rejected   = res_q.rejected;

`ifndef SYNTHESIS
	// A finished command never reports busy in the same word
	a_done_not_busy: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid_q |-> !(res_q.done_res && res_q.busy_res))
		else $error("done and busy together");

	// Gathered bits only appear on a done word
	a_read_on_done: assert property (@(posedge clk) disable iff (!arst_n)
		(res_valid_q && (res_q.read_value != '0)) |-> res_q.done_res)
		else $error("read value without done");

	// The input side only stalls when both stages are full
	a_stall_full: assert property (@(posedge clk) disable iff (!arst_n)
		!cmd.ready |-> (valid_s1 && res_valid_q && !res.ready))
		else $error("input stalled with room in the pipeline");
`endif

endmodule
